// ===== design/salru_pkg.sv =====
// salru_pkg: shared types, codes and helpers for the set-associative lru lookup
// no dependencies; imported by every module of the block

package salru_pkg;

    localparam int CNT_W     = 32;
    localparam int IDX_VAL_W = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } salru_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] write_miss_total;
        logic [CNT_W-1:0] write_total;
        logic [CNT_W-1:0] read_miss_total;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] access_total;
        logic             bad_command;
        logic             evicted;
        logic [2:0]       way;
        logic             hit;
    } salru_result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== design/salru_front.sv =====
// salru_front: accepts access beats, splits the address into set and tag
// depends on salru_pkg; set index reduced modulo MAX_SETS over two stages

module salru_front
    import salru_pkg::*;
#(
    parameter int MAX_SETS   = 1024,
    parameter int ADDR_WIDTH = 64,
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int ENTRY_W   = 2 + SET_W + ADDR_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CFG_W-1:0]   offset_bits,
    input  logic [CFG_W-1:0]   index_bits,
    input  logic               accept_en,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               push_valid,
    input  logic               push_ready,
    output logic [ENTRY_W-1:0] push_data
);

    localparam int    LOG_SETS = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 0;
    localparam int    RSH      = IDX_VAL_W + LOG_SETS;
    localparam int    RECIP_W  = IDX_VAL_W + 2;
    localparam int    PROD_W   = IDX_VAL_W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(MAX_SETS) - 1)
                                 / longint'(MAX_SETS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [ADDR_WIDTH-1:0] in_tag;
    logic [IDX_VAL_W-1:0]  imask;
    logic [IDX_VAL_W-1:0]  in_idx;
    logic                  in_bad;
    logic                  in_write;
    logic                  adv1;
    logic                  adv2;

    logic                  s1_valid_reg;
    logic                  s1_bad_reg;
    logic                  s1_write_reg;
    logic [IDX_VAL_W-1:0]  s1_idx_reg;
    logic [ADDR_WIDTH-1:0] s1_tag_reg;

    logic                  s2_valid_reg;
    logic                  s2_bad_reg;
    logic                  s2_write_reg;
    logic [IDX_VAL_W-1:0]  s2_idx_reg;
    logic [IDX_VAL_W-1:0]  s2_quot_reg;
    logic [ADDR_WIDTH-1:0] s2_tag_reg;

    logic [PROD_W-1:0]     prod;
    logic [CNT_W-1:0]      quot_scaled;
    logic [CNT_W-1:0]      rem;

    always_comb
    begin
        addr_m  = s_tdata[ADDR_WIDTH-1:0];
        shifted = addr_m >> offset_bits;
        for (int k = 0; k < IDX_VAL_W; k++)
        begin
            imask[k] = (5'(k) < {1'b0, index_bits});
        end
        in_idx   = shifted[IDX_VAL_W-1:0] & imask;
        in_tag   = shifted >> index_bits;
        in_bad   = (s_tuser != OP_READ) && (s_tuser != OP_WRITE);
        in_write = (s_tuser == OP_WRITE);
    end

    assign adv2     = !s2_valid_reg || push_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_tready = adv1 && accept_en;

    assign prod        = PROD_W'(s1_idx_reg) * PROD_W'(RECIP);
    assign quot_scaled = CNT_W'(s2_quot_reg) * CNT_W'(MAX_SETS);
    assign rem         = CNT_W'(s2_idx_reg) - quot_scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= s_tvalid && accept_en;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_bad_reg   <= in_bad;
            s1_write_reg <= in_write;
            s1_idx_reg   <= in_idx;
            s1_tag_reg   <= in_tag;
        end
        if (adv2)
        begin
            s2_bad_reg   <= s1_bad_reg;
            s2_write_reg <= s1_write_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_quot_reg  <= IDX_VAL_W'(prod >> RSH);
            s2_tag_reg   <= s1_tag_reg;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_data  = {s2_bad_reg, s2_write_reg, SET_W'(rem), s2_tag_reg};

endmodule

// ===== design/salru_queue.sv =====
// salru_queue: two-entry queue between the address front and the lookup back
// depends on salru_pkg only through the common import style

module salru_queue
    import salru_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/salru_back.sv =====
// salru_back: set row memories, tag compare, lru update, counters, result register
// depends on salru_pkg; takes entries from salru_queue

module salru_back
    import salru_pkg::*;
#(
    parameter int MAX_SETS   = 1024,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64,
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int ENTRY_W   = 2 + SET_W + ADDR_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CFG_W-1:0]   ways_in_use,
    output logic               lines_ready,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output salru_result_t      m_result
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [WAY_W-1:0] RANK_TOP = WAY_W'(MAX_WAYS - 1);
    localparam logic [4:0]       WAYS_MAX = 5'(MAX_WAYS);

    logic [MAX_WAYS-1:0]            valid_mem [MAX_SETS];
    logic [MAX_WAYS*WAY_W-1:0]      rank_mem  [MAX_SETS];
    logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_mem   [MAX_SETS];

    salru_state_t state_reg;
    salru_state_t state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] clr_cnt_next;

    logic                  bad_reg;
    logic                  write_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;

    logic [MAX_WAYS-1:0]            rd_valid_reg;
    logic [MAX_WAYS*WAY_W-1:0]      rd_rank_reg;
    logic [MAX_WAYS*ADDR_WIDTH-1:0] rd_tag_reg;

    logic [CNT_W-1:0] access_reg;
    logic [CNT_W-1:0] miss_reg;
    logic [CNT_W-1:0] read_reg;
    logic [CNT_W-1:0] read_miss_reg;
    logic [CNT_W-1:0] write_cnt_reg;
    logic [CNT_W-1:0] write_miss_reg;
    logic [CNT_W-1:0] access_next;
    logic [CNT_W-1:0] miss_next;
    logic [CNT_W-1:0] read_next;
    logic [CNT_W-1:0] read_miss_next;
    logic [CNT_W-1:0] write_cnt_next;
    logic [CNT_W-1:0] write_miss_next;

    logic          out_valid_reg;
    salru_result_t out_res_reg;
    salru_result_t res;

    logic                  q_bad;
    logic                  q_write;
    logic [SET_W-1:0]      q_set;
    logic [ADDR_WIDTH-1:0] q_tag;
    logic [SET_W-1:0]      rd_addr;
    logic                  clr_we;
    logic                  look_done;
    logic                  line_we;

    logic [4:0]            ways_eff;
    logic [WAY_W-1:0]      rank_r [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] tag_r  [MAX_WAYS];
    logic [MAX_WAYS-1:0]   inuse;
    logic [MAX_WAYS-1:0]   match;
    logic [MAX_WAYS-1:0]   free;
    logic [MAX_WAYS-1:0]   vic;
    logic                  hit_any;
    logic                  free_any;
    logic                  miss_free;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      vic_way;
    logic [WAY_W-1:0]      target;
    logic [WAY_W-1:0]      old_rank;
    logic [MAX_WAYS-1:0]            new_valid;
    logic [MAX_WAYS*WAY_W-1:0]      new_rank_row;
    logic [MAX_WAYS*ADDR_WIDTH-1:0] new_tag_row;

    assign {q_bad, q_write, q_set, q_tag} = q_data;
    assign lines_ready = (state_reg != ST_CLEAR);

    // control
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        look_done    = 1'b0;
        clr_we       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    look_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bad_reg   <= q_bad;
            write_reg <= q_write;
            set_reg   <= q_set;
            tag_reg   <= q_tag;
        end
    end

    // set row memories
    assign rd_addr = (state_reg == ST_IDLE) ? q_set : set_reg;
    assign line_we = look_done && !bad_reg;

    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            valid_mem[clr_cnt_reg] <= '0;
        end
        else if (line_we)
        begin
            valid_mem[set_reg] <= new_valid;
            rank_mem[set_reg]  <= new_rank_row;
            tag_mem[set_reg]   <= new_tag_row;
        end
        rd_valid_reg <= valid_mem[rd_addr];
        rd_rank_reg  <= rank_mem[rd_addr];
        rd_tag_reg   <= tag_mem[rd_addr];
    end

    // lookup and replacement
    always_comb
    begin
        if (ways_in_use == '0)
        begin
            ways_eff = 5'd1;
        end
        else if (5'(ways_in_use) > WAYS_MAX)
        begin
            ways_eff = WAYS_MAX;
        end
        else
        begin
            ways_eff = 5'(ways_in_use);
        end

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            rank_r[i] = rd_rank_reg[i*WAY_W +: WAY_W];
            tag_r[i]  = rd_tag_reg[i*ADDR_WIDTH +: ADDR_WIDTH];
            inuse[i]  = (5'(i) < ways_eff);
            match[i]  = inuse[i] && rd_valid_reg[i] && (tag_r[i] == tag_reg);
            free[i]   = inuse[i] && !rd_valid_reg[i];
        end

        // highest rank wins, lowest way on a tie
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            vic[i] = inuse[i];
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (inuse[j] && (j < i) && (rank_r[i] <= rank_r[j]))
                begin
                    vic[i] = 1'b0;
                end
                if (inuse[j] && (j > i) && (rank_r[i] < rank_r[j]))
                begin
                    vic[i] = 1'b0;
                end
            end
        end

        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (free[i])
            begin
                free_way = WAY_W'(i);
            end
            if (vic[i])
            begin
                vic_way = WAY_W'(i);
            end
        end

        hit_any   = |match;
        free_any  = |free;
        miss_free = !hit_any && free_any;
        target    = hit_any ? hit_way : (free_any ? free_way : vic_way);
        old_rank  = rank_r[target];

        new_valid = rd_valid_reg;
        if (!hit_any)
        begin
            new_valid[target] = 1'b1;
        end

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_W'(i) == target)
            begin
                new_rank_row[i*WAY_W +: WAY_W] = '0;
            end
            else if (inuse[i] && rd_valid_reg[i] && (miss_free || (rank_r[i] < old_rank)))
            begin
                new_rank_row[i*WAY_W +: WAY_W] =
                    (rank_r[i] >= RANK_TOP) ? RANK_TOP : rank_r[i] + 1'b1;
            end
            else
            begin
                new_rank_row[i*WAY_W +: WAY_W] = rank_r[i];
            end
        end

        new_tag_row = rd_tag_reg;
        if (!hit_any)
        begin
            new_tag_row[target*ADDR_WIDTH +: ADDR_WIDTH] = tag_reg;
        end
    end

    // counters
    always_comb
    begin
        access_next     = access_reg;
        miss_next       = miss_reg;
        read_next       = read_reg;
        read_miss_next  = read_miss_reg;
        write_cnt_next  = write_cnt_reg;
        write_miss_next = write_miss_reg;
        if (!bad_reg)
        begin
            access_next = sat_inc(access_reg);
            if (write_reg)
            begin
                write_cnt_next = sat_inc(write_cnt_reg);
            end
            else
            begin
                read_next = sat_inc(read_reg);
            end
            if (!hit_any)
            begin
                miss_next = sat_inc(miss_reg);
                if (write_reg)
                begin
                    write_miss_next = sat_inc(write_miss_reg);
                end
                else
                begin
                    read_miss_next = sat_inc(read_miss_reg);
                end
            end
        end

        res.hit              = !bad_reg && hit_any;
        res.way              = bad_reg ? 3'd0 : 3'(target);
        res.evicted          = !bad_reg && !hit_any && !free_any;
        res.bad_command      = bad_reg;
        res.access_total     = access_next;
        res.miss_total       = miss_next;
        res.read_total       = read_next;
        res.read_miss_total  = read_miss_next;
        res.write_total      = write_cnt_next;
        res.write_miss_total = write_miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg     <= '0;
            miss_reg       <= '0;
            read_reg       <= '0;
            read_miss_reg  <= '0;
            write_cnt_reg  <= '0;
            write_miss_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (look_done)
            begin
                access_reg     <= access_next;
                miss_reg       <= miss_next;
                read_reg       <= read_next;
                read_miss_reg  <= read_miss_next;
                write_cnt_reg  <= write_cnt_next;
                write_miss_reg <= write_miss_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_done)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_res_reg;

    a_miss_le_access: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.miss_total <= out_res_reg.access_total))
        else $error("miss count above access count");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.hit && out_res_reg.evicted))
        else $error("hit reported with eviction");

    a_single_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK && !bad_reg && !hit_any && !free_any) |-> $onehot(vic))
        else $error("lru victim not unique");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass restarted");

endmodule

// ===== design/set_assoc_cache_lru_lookup.sv =====
// set_assoc_cache_lru_lookup: set-associative cache lookup with true-lru replacement
// depends on salru_pkg, salru_front, salru_queue, salru_back
//
//  channel  | dir | handshake           | payload
//  s_       | in  | s_tvalid / s_tready | s_tdata address, s_tuser operation
//  m_       | out | m_tvalid / m_tready | m_tdata hit..write_miss_total, m_tuser bad_command
//  cfg_     | in  | cfg_we              | cfg_index register, cfg_data value
//
//  front: two register stages (address split, set index reduction) into a two-entry queue
//  back: one access at a time, limited by the single set row memory port: ST_IDLE reads
//  the row, ST_LOOK compares, picks the way, writes the row back when the output is free
//  after reset a clearing pass over all MAX_SETS set rows runs with s_tready low
//  a finished result waits in the output register while the front and queue accept until full

module set_assoc_cache_lru_lookup
    import salru_pkg::*;
#(
    parameter int MAX_SETS   = 1024,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // address[63:0]
    input  logic [1:0]           s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit[0], way[3:1], evicted[4], access_total[36:5], miss_total[68:37],
    // read_total[100:69], read_miss_total[132:101], write_total[164:133],
    // write_miss_total[196:165], zero[199:197]
    output logic [199:0]         m_tdata,
    output logic                 m_tuser,   // bad_command[0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ENTRY_W = 2 + SET_W + ADDR_WIDTH;

    logic [CFG_W-1:0] offset_bits_reg;
    logic [CFG_W-1:0] index_bits_reg;
    logic [CFG_W-1:0] ways_in_use_reg;

    logic               lines_ready;
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    salru_result_t      result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 4'd6;
            index_bits_reg  <= 4'd6;
            ways_in_use_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    salru_front #(
        .MAX_SETS   (MAX_SETS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .offset_bits (offset_bits_reg),
        .index_bits  (index_bits_reg),
        .accept_en   (lines_ready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    salru_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    salru_back #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ways_in_use (ways_in_use_reg),
        .lines_ready (lines_ready),
        .q_valid     (pop_valid),
        .q_pop       (pop_ready),
        .q_data      (pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {3'b000,
                      result.write_miss_total,
                      result.write_total,
                      result.read_miss_total,
                      result.read_total,
                      result.miss_total,
                      result.access_total,
                      result.evicted,
                      result.way,
                      result.hit};
    assign m_tuser = result.bad_command;

endmodule
